// File: hdl/rts_pkg.sv
package rts_pkg;

  localparam int NAME_BYTES   = 8;
  localparam int KEY_W        = 64;
  localparam int QTY_W        = 16;
  localparam int PRIO_W       = 3;
  localparam int CMPCNT_W     = 7;
  localparam int DEF_CAPACITY = 16;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_SORT   = 3'd2,
    ACT_SEARCH = 3'd3,
    ACT_LIST   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_NOT_SORTED = 3'd3,
    ST_BAD_CRIT   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CRIT_NAME = 2'd0,
    CRIT_TYPE = 2'd1,
    CRIT_PRIO = 2'd2,
    CRIT_BAD  = 2'd3
  } crit_t;

  typedef enum logic [1:0] {
    WSEL_IN  = 2'd0,
    WSEL_RD  = 2'd1,
    WSEL_KEY = 2'd2
  } wsel_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [KEY_W-1:0]  name_key;
    logic [KEY_W-1:0]  type_key;
    logic [QTY_W-1:0]  quantity;
    logic [PRIO_W-1:0] priority_req;
    logic [1:0]        sort_key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [KEY_W-1:0]    out_name;
    logic [KEY_W-1:0]    out_type;
    logic [QTY_W-1:0]    out_quantity;
    logic [PRIO_W-1:0]   out_priority;
    logic [CMPCNT_W-1:0] compare_count;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  name;
    logic [KEY_W-1:0]  kind;
    logic [QTY_W-1:0]  qty;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic    capture;
    logic    rd;
    logic    we;
    wsel_t   wsel;
    logic    load_key;
    logic    clr_cnt;
    logic    inc_cnt;
    logic    emit;
    logic    emit_rec;
    logic    last;
    status_t status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  can_emit;
    logic  name_eq;
    logic  name_lt;
    logic  shift;
    logic [2:0] action;
    crit_t crit;
  } dp_sts_t;

  // keep the first nbytes bytes, drop everything after the first zero byte
  function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] key,
                                                     input int nbytes);
    logic [KEY_W-1:0] res;
    logic             done;
    logic [7:0]       b;
    res  = '0;
    done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b = key[KEY_W-1-8*i -: 8];
      if (i >= nbytes || b == 8'd0) done = 1'b1;
      if (!done) res[KEY_W-1-8*i -: 8] = b;
    end
    return res;
  endfunction

endpackage

// File: hdl/rts_datapath.sv
module rts_datapath #(
  parameter int CAPACITY = rts_pkg::DEF_CAPACITY,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  logic               clk,
  input  logic               rst,
  input  rts_pkg::in_item_t  in_data,
  input  rts_pkg::dp_cmd_t   cmd,
  input  logic [IDX_W-1:0]   rd_addr,
  input  logic [IDX_W-1:0]   wr_addr,
  output rts_pkg::dp_sts_t   sts,
  output logic               out_valid,
  input  logic               out_ready,
  output rts_pkg::out_item_t out_data
);
  import rts_pkg::*;

  entry_t              mem [CAPACITY];
  entry_t              rd_q;
  entry_t              key;
  entry_t              req;
  entry_t              wdata;
  logic [2:0]          act;
  crit_t               crit;
  logic [CMPCNT_W-1:0] cmp_cnt;
  logic                out_valid_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req.name <= normalize_key(in_data.name_key, NAME_BYTES);
      req.kind <= normalize_key(in_data.type_key, 8);
      req.qty  <= in_data.quantity;
      if (in_data.priority_req == 3'd0)     req.prio <= 3'd1;
      else if (in_data.priority_req > 3'd5) req.prio <= 3'd5;
      else                                  req.prio <= in_data.priority_req;
      act  <= in_data.action;
      crit <= crit_t'(in_data.sort_key);
    end
    if (cmd.load_key) key <= rd_q;
  end

  always_comb begin
    case (cmd.wsel)
      WSEL_IN:  wdata = req;
      WSEL_RD:  wdata = rd_q;
      default:  wdata = key;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.we) mem[wr_addr] <= wdata;
    if (cmd.rd) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_cnt <= '0;
    end else if (cmd.clr_cnt) begin
      cmp_cnt <= '0;
    end else if (cmd.inc_cnt && cmp_cnt != {CMPCNT_W{1'b1}}) begin
      cmp_cnt <= cmp_cnt + 1'b1;
    end
  end

  always_comb begin
    sts.can_emit = !out_valid || out_ready;
    sts.name_eq  = (rd_q.name == req.name);
    sts.name_lt  = (rd_q.name < req.name);
    case (crit)
      CRIT_NAME: sts.shift = rd_q.name > key.name;
      CRIT_TYPE: sts.shift = rd_q.kind > key.kind;
      default:   sts.shift = rd_q.prio < key.prio;
    endcase
    sts.action = act;
    sts.crit   = crit;
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit)     out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.status        <= cmd.status;
      out_data.out_name      <= cmd.emit_rec ? rd_q.name : '0;
      out_data.out_type      <= cmd.emit_rec ? rd_q.kind : '0;
      out_data.out_quantity  <= cmd.emit_rec ? rd_q.qty : '0;
      out_data.out_priority  <= cmd.emit_rec ? rd_q.prio : '0;
      out_data.compare_count <= cmp_cnt;
      out_data.last          <= cmd.last;
    end
  end

endmodule

// File: hdl/rts_ctrl.sv
module rts_ctrl #(
  parameter int CAPACITY = rts_pkg::DEF_CAPACITY,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rts_pkg::dp_sts_t sts,
  output rts_pkg::dp_cmd_t cmd,
  output logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] wr_addr
);
  import rts_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DISP   = 14'b00000000000010,
    S_RESP   = 14'b00000000000100,
    S_RM_RD  = 14'b00000000001000,
    S_RM_EV  = 14'b00000000010000,
    S_SH_RD  = 14'b00000000100000,
    S_SH_WR  = 14'b00000001000000,
    S_SO_I   = 14'b00000010000000,
    S_SO_KEY = 14'b00000100000000,
    S_SO_RD  = 14'b00001000000000,
    S_SO_CMP = 14'b00010000000000,
    S_BS_RD  = 14'b00100000000000,
    S_BS_EV  = 14'b01000000000000,
    S_LS     = 14'b10000000000000
  } state_t;

  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  state_t           state, state_next;
  logic [CNT_W-1:0] n, n_next;
  logic             sorted, sorted_next;
  logic [CNT_W-1:0] i, i_next;
  logic [CNT_W-1:0] jp, jp_next;
  logic [CNT_W-1:0] lo, lo_next;
  logic [CNT_W-1:0] hp, hp_next;
  status_t          resp_st, resp_st_next;
  logic             list_rd, list_rd_next;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] i_inc;
  logic [CNT_W-1:0] jp_dec;

  assign in_ready = (state == S_IDLE);
  assign mid_sum  = {1'b0, lo} + {1'b0, hp} - 1'b1;
  assign mid      = mid_sum[CNT_W:1];
  assign i_inc    = i + 1'b1;
  assign jp_dec   = jp - 1'b1;

  always_comb begin
    state_next   = state;
    n_next       = n;
    sorted_next  = sorted;
    i_next       = i;
    jp_next      = jp;
    lo_next      = lo;
    hp_next      = hp;
    resp_st_next = resp_st;
    list_rd_next = list_rd;
    cmd          = '0;
    cmd.wsel     = WSEL_IN;
    cmd.status   = ST_OK;
    rd_addr      = i[IDX_W-1:0];
    wr_addr      = i[IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        case (sts.action)
          ACT_ADD: begin
            state_next = S_RESP;
            if (n == CAP_C) begin
              resp_st_next = ST_FULL;
            end else begin
              cmd.we       = 1'b1;
              wr_addr      = n[IDX_W-1:0];
              n_next       = n + 1'b1;
              sorted_next  = 1'b0;
              resp_st_next = ST_OK;
            end
          end
          ACT_REMOVE: begin
            i_next     = '0;
            state_next = S_RM_RD;
          end
          ACT_SORT: begin
            if (sts.crit == CRIT_BAD) begin
              resp_st_next = ST_BAD_CRIT;
              state_next   = S_RESP;
            end else begin
              cmd.clr_cnt = 1'b1;
              i_next      = CNT_W'(1);
              state_next  = S_SO_I;
            end
          end
          ACT_SEARCH: begin
            if (!sorted) begin
              resp_st_next = ST_NOT_SORTED;
              state_next   = S_RESP;
            end else begin
              lo_next    = '0;
              hp_next    = n;
              state_next = S_BS_RD;
            end
          end
          ACT_LIST: begin
            if (n == '0) begin
              resp_st_next = ST_OK;
              state_next   = S_RESP;
            end else begin
              i_next       = '0;
              list_rd_next = 1'b1;
              state_next   = S_LS;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_RESP: begin
        if (sts.can_emit) begin
          cmd.emit   = 1'b1;
          cmd.last   = 1'b1;
          cmd.status = resp_st;
          state_next = S_IDLE;
        end
      end
      S_RM_RD: begin
        if (i == n) begin
          resp_st_next = ST_NOT_FOUND;
          state_next   = S_RESP;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_RM_EV;
        end
      end
      S_RM_EV: begin
        if (sts.name_eq) begin
          state_next = S_SH_RD;
        end else begin
          i_next     = i_inc;
          state_next = S_RM_RD;
        end
      end
      S_SH_RD: begin
        if (i_inc >= n) begin
          n_next       = n - 1'b1;
          resp_st_next = ST_OK;
          state_next   = S_RESP;
        end else begin
          cmd.rd     = 1'b1;
          rd_addr    = i_inc[IDX_W-1:0];
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.we     = 1'b1;
        cmd.wsel   = WSEL_RD;
        i_next     = i_inc;
        state_next = S_SH_RD;
      end
      S_SO_I: begin
        if (i >= n) begin
          sorted_next  = (sts.crit == CRIT_NAME);
          resp_st_next = ST_OK;
          state_next   = S_RESP;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_SO_KEY;
        end
      end
      S_SO_KEY: begin
        cmd.load_key = 1'b1;
        jp_next      = i;
        state_next   = S_SO_RD;
      end
      S_SO_RD: begin
        if (jp == '0) begin
          cmd.we     = 1'b1;
          cmd.wsel   = WSEL_KEY;
          wr_addr    = '0;
          i_next     = i_inc;
          state_next = S_SO_I;
        end else begin
          cmd.rd     = 1'b1;
          rd_addr    = jp_dec[IDX_W-1:0];
          state_next = S_SO_CMP;
        end
      end
      S_SO_CMP: begin
        cmd.inc_cnt = 1'b1;
        cmd.we      = 1'b1;
        wr_addr     = jp[IDX_W-1:0];
        if (sts.shift) begin
          cmd.wsel   = WSEL_RD;
          jp_next    = jp_dec;
          state_next = S_SO_RD;
        end else begin
          cmd.wsel   = WSEL_KEY;
          i_next     = i_inc;
          state_next = S_SO_I;
        end
      end
      S_BS_RD: begin
        if (lo >= hp) begin
          resp_st_next = ST_NOT_FOUND;
          state_next   = S_RESP;
        end else begin
          cmd.rd     = 1'b1;
          rd_addr    = mid[IDX_W-1:0];
          state_next = S_BS_EV;
        end
      end
      S_BS_EV: begin
        if (sts.name_eq) begin
          if (sts.can_emit) begin
            cmd.emit     = 1'b1;
            cmd.emit_rec = 1'b1;
            cmd.last     = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          if (sts.name_lt) lo_next = mid + 1'b1;
          else             hp_next = mid;
          state_next = S_BS_RD;
        end
      end
      S_LS: begin
        // alternate: fetch record i, then emit it once the output slot frees
        if (list_rd) begin
          cmd.rd       = 1'b1;
          list_rd_next = 1'b0;
        end else if (sts.can_emit) begin
          cmd.emit     = 1'b1;
          cmd.emit_rec = 1'b1;
          cmd.last     = (i_inc == n);
          if (i_inc == n) begin
            state_next = S_IDLE;
          end else begin
            i_next       = i_inc;
            list_rd_next = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      n       <= '0;
      sorted  <= 1'b0;
      list_rd <= 1'b0;
    end else begin
      state   <= state_next;
      n       <= n_next;
      sorted  <= sorted_next;
      list_rd <= list_rd_next;
    end
  end

  always_ff @(posedge clk) begin
    i       <= i_next;
    jp      <= jp_next;
    lo      <= lo_next;
    hp      <= hp_next;
    resp_st <= resp_st_next;
  end

endmodule

// File: hdl/record_table_sort_search_core.sv
// Record table of CAPACITY entries kept in one simple dual-port table memory (one
// read, one write per cycle, registered read). One action at a time: remove scans
// the records for the name and then moves each later record down one place,
// search makes at most log2(CAPACITY)+1 probes, and list fetches each record
// and then emits it. Sort is a stable insertion sort stepped through the memory.
// Result beats sit in an output register, so the block only stalls when a new
// result is due and the previous one is untaken.
module record_table_sort_search_core #(
  parameter int CAPACITY = rts_pkg::DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rts_pkg::out_item_t out_data
);
  import rts_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  rts_ctrl #(
    .CAPACITY(CAPACITY),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  rts_datapath #(
    .CAPACITY(CAPACITY),
    .IDX_W   (IDX_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.can_emit)
    else $error("result beat issued while output register is occupied");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("controller stayed ready after taking an action");

  a_no_write_on_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !cmd.we)
    else $error("table write coincides with a result beat");

endmodule

// File: tb/record_table_checker.sv
module record_table_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  rts_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  rts_pkg::out_item_t out_data,
  output int                 errors,
  output int                 pending
);
  import rts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = DEF_CAPACITY;

  entry_t    tbl[CAP];
  int        n_rec;
  logic      by_name;
  int        last_cmp;
  out_item_t beats_due[$];

  assign pending = beats_due.size();

  function automatic logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] k, int nb);
    logic [KEY_W-1:0] r;
    r = '0;
    for (int i = 0; i < nb; i++) begin
      if (k[KEY_W-1-8*i -: 8] == 8'd0) break;
      r[KEY_W-1-8*i -: 8] = k[KEY_W-1-8*i -: 8];
    end
    return r;
  endfunction

  function automatic void queue_beat(status_t st, int idx, logic lst);
    out_item_t o;
    o = '0;
    o.status = st;
    if (idx >= 0) begin
      o.out_name     = tbl[idx].name;
      o.out_type     = tbl[idx].kind;
      o.out_quantity = tbl[idx].qty;
      o.out_priority = tbl[idx].prio;
    end
    o.compare_count = (last_cmp > 127) ? 7'd127 : last_cmp[6:0];
    o.last = lst;
    beats_due.push_back(o);
  endfunction

  function automatic void insertion_sort(crit_t c);
    entry_t k;
    int     j;
    logic   mv;
    last_cmp = 0;
    for (int i = 1; i < n_rec; i++) begin
      k = tbl[i];
      j = i - 1;
      while (j >= 0) begin
        last_cmp++;
        case (c)
          CRIT_NAME: mv = tbl[j].name > k.name;
          CRIT_TYPE: mv = tbl[j].kind > k.kind;
          default:   mv = tbl[j].prio < k.prio;
        endcase
        if (!mv) break;
        tbl[j+1] = tbl[j];
        j--;
      end
      tbl[j+1] = k;
    end
    by_name = (c == CRIT_NAME);
  endfunction

  function automatic void predict(in_item_t it);
    logic [KEY_W-1:0]  nm;
    logic [PRIO_W-1:0] p;
    int                i, lo, hi, mid;
    nm = trim_key(it.name_key, NAME_BYTES);
    case (it.action)
      ACT_ADD: begin
        if (n_rec >= CAP) queue_beat(ST_FULL, -1, 1'b1);
        else begin
          p = it.priority_req;
          if (p < 1) p = 1;
          if (p > 5) p = 5;
          tbl[n_rec] = '{name: nm, kind: trim_key(it.type_key, 8),
                         qty: it.quantity, prio: p};
          n_rec++;
          by_name = 1'b0;
          queue_beat(ST_OK, -1, 1'b1);
        end
      end
      ACT_REMOVE: begin
        for (i = 0; i < n_rec; i++) if (tbl[i].name == nm) break;
        if (i >= n_rec) queue_beat(ST_NOT_FOUND, -1, 1'b1);
        else begin
          for (; i < n_rec - 1; i++) tbl[i] = tbl[i+1];
          n_rec--;
          queue_beat(ST_OK, -1, 1'b1);
        end
      end
      ACT_SORT: begin
        if (crit_t'(it.sort_key) == CRIT_BAD) queue_beat(ST_BAD_CRIT, -1, 1'b1);
        else begin
          insertion_sort(crit_t'(it.sort_key));
          queue_beat(ST_OK, -1, 1'b1);
        end
      end
      ACT_SEARCH: begin
        if (!by_name) queue_beat(ST_NOT_SORTED, -1, 1'b1);
        else begin
          lo = 0;
          hi = n_rec - 1;
          mid = -1;
          while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (tbl[mid].name == nm) break;
            if (tbl[mid].name < nm) lo = mid + 1;
            else hi = mid - 1;
          end
          if (lo <= hi) queue_beat(ST_OK, mid, 1'b1);
          else queue_beat(ST_NOT_FOUND, -1, 1'b1);
        end
      end
      ACT_LIST: begin
        if (n_rec == 0) queue_beat(ST_OK, -1, 1'b1);
        for (i = 0; i < n_rec; i++) queue_beat(ST_OK, i, i == n_rec - 1);
      end
      default: ; // unused codes do nothing
    endcase
  endfunction

  task automatic flag(string what, logic [KEY_W-1:0] exp_v, logic [KEY_W-1:0] got_v);
    if (errors < 10)
      $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      n_rec    <= 0;
      by_name  <= 1'b0;
      last_cmp <= 0;
      errors   <= 0;
      beats_due.delete();
    end else begin
      if (in_valid && in_ready) predict(in_data);
      if (out_valid && out_ready) begin
        if (beats_due.size() == 0) begin
          if (errors < 10) $display("unexpected result beat %h", out_data);
          errors++;
        end else begin
          e = beats_due.pop_front();
          if (out_data.status != e.status) flag("status", e.status, out_data.status);
          if (out_data.out_name != e.out_name) flag("name", e.out_name, out_data.out_name);
          if (out_data.out_type != e.out_type) flag("type", e.out_type, out_data.out_type);
          if (out_data.out_quantity != e.out_quantity)
            flag("quantity", e.out_quantity, out_data.out_quantity);
          if (out_data.out_priority != e.out_priority)
            flag("priority", e.out_priority, out_data.out_priority);
          if (out_data.compare_count != e.compare_count)
            flag("compare_count", e.compare_count, out_data.compare_count);
          if (out_data.last != e.last) flag("last", e.last, out_data.last);
        end
      end
    end
  end
endmodule

// File: tb/record_table_sort_search_core_tb.sv
module record_table_sort_search_core_tb;
  import rts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ACT_SPARE = 3'd5;
  localparam int         STALL_LIMIT = 3000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        errors;
  int        pending;
  int        quiet_cycles = 0;
  logic      burst = 1'b0;

  logic [KEY_W-1:0] name_pool[10];
  logic [KEY_W-1:0] type_pool[4];

  always #5 clk = ~clk;

  record_table_sort_search_core dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  record_table_checker chk (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .errors, .pending
  );

  // short string key, sometimes with junk after the terminator
  function automatic logic [KEY_W-1:0] make_key();
    logic [KEY_W-1:0] k;
    int               len;
    k = {$urandom, $urandom};
    if ($urandom_range(0, 5) == 0) return k;
    len = $urandom_range(1, 7);
    for (int i = 0; i < 8; i++) begin
      if (k[KEY_W-1-8*i -: 8] == 8'd0) k[KEY_W-1-8*i -: 8] = 8'h41;
      if (i == len) begin
        k[KEY_W-1-8*i -: 8] = 8'd0;
        // in most keys, clear every byte below the terminator
        if ($urandom_range(0, 3) != 0) k = k & ~({KEY_W{1'b1}} >> (8*i + 8));
        break;
      end
    end
    return k;
  endfunction

  task automatic send(logic [2:0] act, logic [KEY_W-1:0] nm, logic [KEY_W-1:0] ty,
                      logic [QTY_W-1:0] q, logic [PRIO_W-1:0] p, logic [1:0] crit);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, name_key: nm, type_key: ty, quantity: q,
                  priority_req: p, sort_key: crit};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random();
    int               r;
    logic [2:0]       act;
    logic [KEY_W-1:0] nm;
    r = $urandom_range(0, 99);
    if (r < 32) act = ACT_ADD;
    else if (r < 47) act = ACT_REMOVE;
    else if (r < 65) act = ACT_SORT;
    else if (r < 85) act = ACT_SEARCH;
    else if (r < 95) act = ACT_LIST;
    else act = 3'($urandom_range(5, 7));
    nm = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : name_pool[$urandom_range(0, 9)];
    send(act, nm, type_pool[$urandom_range(0, 3)], 16'($urandom),
         3'($urandom_range(0, 7)), ($urandom_range(0, 9) == 0) ? CRIT_BAD
                                   : 2'($urandom_range(0, 2)));
  endtask

  // result side
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 10; i++) name_pool[i] = make_key();
    for (int i = 0; i < 4; i++) type_pool[i] = make_key();
    type_pool[1] = type_pool[0];  // equal types check stability
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(ACT_LIST, '0, '0, '0, 3'd1, CRIT_NAME);
    send(ACT_SEARCH, name_pool[0], '0, '0, 3'd1, CRIT_NAME);
    send(ACT_SORT, '0, '0, '0, 3'd1, CRIT_BAD);
    send(ACT_REMOVE, name_pool[0], '0, '0, 3'd1, CRIT_NAME);
    send(ACT_ADD, '1, '1, 16'hFFFF, 3'd7, CRIT_BAD);
    send(ACT_ADD, '0, '0, 16'h0000, 3'd0, CRIT_NAME);
    send(ACT_ADD, 64'h4142_0043_4400_0000, 64'h5800_5959_0000_0000, 16'h1234, 3'd6,
         CRIT_TYPE);
    for (int i = 0; i < 14; i++)
      send(ACT_ADD, name_pool[i % 10], type_pool[i % 4], 16'($urandom),
           3'($urandom_range(1, 5)), CRIT_NAME);
    send(ACT_ADD, name_pool[0], '0, '0, 3'd3, CRIT_NAME);
    send(ACT_SORT, '0, '0, '0, 3'd1, CRIT_PRIO);
    send(ACT_SORT, '0, '0, '0, 3'd1, CRIT_NAME);
    send(ACT_SEARCH, name_pool[3], '0, '0, 3'd1, CRIT_NAME);
    send(ACT_LIST, '0, '0, '0, 3'd1, CRIT_NAME);
    send(ACT_SPARE, '0, '0, '0, 3'd1, CRIT_NAME);

    for (int k = 0; k < 300; k++) begin
      if ($urandom_range(0, 29) == 0) burst = ~burst;
      if (k == 150) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_random();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
